// File: hw/rtl/cqs_pkg.sv
// Shared constants, codes and types of the circular queue with search.
// Used by the channel interfaces, the storage cell and the top level.
`default_nettype none

package cqs_pkg;

   localparam int DEPTH        = 8;
   localparam int SLOT_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WORD_W       = 32;
   localparam int CMD_W        = 2;
   localparam int STAT_W       = 2;
   localparam int SLOT_FOUND_W = 3;

   // request commands
   localparam logic [CMD_W-1:0] CMD_ENQ    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DEQ    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

   // response status codes
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
   localparam logic [STAT_W-1:0] STAT_MISS  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_SEARCH = 2'b10
   } cqs_state_type;

   // control broadcast to every cell
   typedef struct packed {
      logic              start;
      logic [SLOT_W-1:0] head;
      logic [SLOT_W-1:0] tail;
      logic              wr_en;
      logic [SLOT_W-1:0] wr_slot;
   } cqs_ctl_type;

   // search outcome reported by one cell
   typedef struct packed {
      logic hit;
      logic miss;
   } cqs_probe_type;

endpackage

`default_nettype wire

// File: hw/rtl/cqs_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on cqs_pkg for field widths.
`default_nettype none

interface cqs_req_if import cqs_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         cmd;
   logic signed [WORD_W-1:0] item_value;

   modport source (output valid, cmd, item_value, input ready);
   modport sink   (input valid, cmd, item_value, output ready);
endinterface

interface cqs_rsp_if import cqs_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STAT_W-1:0]        status;
   logic signed [WORD_W-1:0] out_value;
   logic [SLOT_FOUND_W-1:0]  slot_found;

   modport source (output valid, status, out_value, slot_found, input ready);
   modport sink   (input valid, status, out_value, slot_found, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/cqs_cell.sv
// One queue slot: holds a stored word and the search token for that slot.
// Depends on cqs_pkg; chained in a ring by circular_queue_with_search.
`default_nettype none

module cqs_cell import cqs_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [SLOT_W-1:0]   idx,
   input  wire cqs_ctl_type         ctl,
   input  wire logic [WORD_W-1:0]   wr_data,
   input  wire logic [WORD_W-1:0]   key,
   input  wire logic                pass_in,
   output logic                     pass_out,
   output logic [WORD_W-1:0]        word,
   output cqs_probe_type            probe
);

   logic [WORD_W-1:0] entry_ff;
   logic [WORD_W-1:0] entry_in;
   logic              tok_ff;
   logic              tok_in;
   logic              eq;
   logic              is_tail;

   always_comb begin
      eq      = (entry_ff == key);
      is_tail = (idx == ctl.tail);
      // token enters at the head cell, or arrives from the previous slot
      tok_in  = (ctl.start && (idx == ctl.head)) || pass_in;
      entry_in = (ctl.wr_en && (ctl.wr_slot == idx)) ? wr_data : entry_ff;
   end

   assign pass_out   = tok_ff && !eq && !is_tail;
   assign probe.hit  = tok_ff && eq;
   assign probe.miss = tok_ff && !eq && is_tail;
   assign word       = entry_ff;

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/circular_queue_with_search.sv
// Circular queue of signed 32-bit words with enqueue, dequeue and search by key.
// Depends on cqs_pkg, cqs_req_if, cqs_rsp_if and cqs_cell.
`default_nettype none

// Circular queue of DEPTH signed words, one response per request. For enqueue,
// dequeue and the unused command code the response register loads at the
// accepting edge. A search hands a token from cell to cell around the ring,
// starting at the head slot, one slot per cycle, until it reaches the first
// match or the tail. One request is in work at a time; a new request is
// taken while the previous response is being taken, and there is no
// startup sequence after reset.
module circular_queue_with_search import cqs_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   cqs_req_if.sink   req_ch,
   cqs_rsp_if.source rsp_ch
);

   cqs_state_type      state_ff, state_in;
   logic [SLOT_W-1:0]  head_ff, head_in;
   logic [SLOT_W-1:0]  tail_ff, tail_in;
   logic               empty_ff, empty_in;
   logic [WORD_W-1:0]  key_ff, key_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0]       rsp_value_ff, rsp_value_in;
   logic [SLOT_FOUND_W-1:0] rsp_slot_ff, rsp_slot_in;

   cqs_ctl_type        ctl;
   logic [WORD_W-1:0]  wr_data;
   logic [WORD_W-1:0]  words [DEPTH];
   cqs_probe_type      probe [DEPTH];
   logic [DEPTH-1:0]   pass;
   logic [DEPTH-1:0]   hit_vec;
   logic [DEPTH-1:0]   miss_vec;
   logic [SLOT_W-1:0]  hit_slot;
   logic               accept;
   logic               rsp_free;
   logic               load;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      return (s == SLOT_W'(DEPTH - 1)) ? '0 : s + SLOT_W'(1);
   endfunction

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         localparam int PREV = (gi == 0) ? DEPTH - 1 : gi - 1;
         cqs_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .idx      (SLOT_W'(gi)),
            .ctl      (ctl),
            .wr_data  (wr_data),
            .key      (key_ff),
            .pass_in  (pass[PREV]),
            .pass_out (pass[gi]),
            .word     (words[gi]),
            .probe    (probe[gi])
         );
      end
   endgenerate

   always_comb begin
      hit_slot = '0;
      for (int i = 0; i < DEPTH; i++) begin
         hit_vec[i]  = probe[i].hit;
         miss_vec[i] = probe[i].miss;
         // at most one cell holds the token, so OR the slot numbers
         hit_slot    = hit_slot | (probe[i].hit ? SLOT_W'(i) : '0);
      end
   end

   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && rsp_free;
   assign accept       = req_ch.valid && req_ch.ready;
   assign wr_data      = req_ch.item_value;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      empty_in      = empty_ff;
      key_in        = key_ff;
      load          = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_value_in  = '0;
      rsp_slot_in   = '0;
      ctl.start     = 1'b0;
      ctl.head      = head_ff;
      ctl.tail      = tail_ff;
      ctl.wr_en     = 1'b0;
      ctl.wr_slot   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               load = 1'b1;
               case (req_ch.cmd)
                  CMD_ENQ: begin
                     if (empty_ff) begin
                        head_in     = '0;
                        tail_in     = '0;
                        empty_in    = 1'b0;
                        ctl.wr_en   = 1'b1;
                        ctl.wr_slot = '0;
                     end else if (next_slot(tail_ff) == head_ff) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        tail_in     = next_slot(tail_ff);
                        ctl.wr_en   = 1'b1;
                        ctl.wr_slot = next_slot(tail_ff);
                     end
                  end
                  CMD_DEQ: begin
                     if (empty_ff) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        rsp_value_in = words[head_ff];
                        if (head_ff == tail_ff) begin
                           head_in  = '0;
                           tail_in  = '0;
                           empty_in = 1'b1;
                        end else begin
                           head_in = next_slot(head_ff);
                        end
                     end
                  end
                  CMD_SEARCH: begin
                     if (empty_ff) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        // hold the response until the token finishes its walk
                        load      = 1'b0;
                        key_in    = req_ch.item_value;
                        ctl.start = 1'b1;
                        state_in  = ST_SEARCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (|hit_vec) begin
               load          = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_slot_in   = SLOT_FOUND_W'(hit_slot);
               state_in      = ST_IDLE;
            end else if (|miss_vec) begin
               load          = 1'b1;
               rsp_status_in = STAT_MISS;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_slot_ff   <= rsp_slot_in;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.out_value  = rsp_value_ff;
   assign rsp_ch.slot_found = rsp_slot_ff;

`ifndef NO_ASSERTIONS
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec | miss_vec))
      else $error("more than one cell holds the search token");

   a_no_token_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ((hit_vec | miss_vec) == '0))
      else $error("search token alive outside a search");

   a_rsp_clear_in_search: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> !rsp_valid_ff)
      else $error("response pending while a search runs");

   a_empty_indices: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (head_ff == '0 && tail_ff == '0))
      else $error("empty queue with nonzero indices");
`endif

endmodule

`default_nettype wire
